// File: src/lpm_pkg.sv
// ---------------------------------------------------------------------------
// IPv4 longest-prefix match: shared package
// Field widths, item and result types, work item type and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpm_pkg;

  // Address and field widths.
  localparam int unsigned ADDR_BITS        = 32;
  localparam int unsigned LEN_W            = 6;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned HIT_W            = 32;

  // Defaults and sizes.
  localparam int unsigned RULE_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam logic [CMD_W-1:0] FALLBACK_RESET = 3'd1;

  // Input mode codes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  // Classified operation carried from the front to the back.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_ROOT   = 2'd2,
    OP_NOP    = 2'd3
  } lpm_op_e;

  // Input item as it arrives on the port.
  typedef struct packed {
    logic                 mode;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     prefix_len;
    logic [CMD_W-1:0]     rule_cmd;
  } lpm_in_t;

  // Result item as it leaves on the port.
  typedef struct packed {
    logic [CMD_W-1:0] result_cmd;
    logic             matched;
    logic [HIT_W-1:0] hit_count;
    logic             status;
  } lpm_out_t;

  // Classified work item: key is the address for a lookup and the masked
  // prefix for an add.
  typedef struct packed {
    lpm_op_e              op;
    logic [ADDR_BITS-1:0] key;
    logic [LEN_W-1:0]     len;
    logic [CMD_W-1:0]     cmd;
  } lpm_work_t;

  // One rule table entry.
  typedef struct packed {
    logic [ADDR_BITS-1:0] prefix;
    logic [LEN_W-1:0]     len;
    logic [CMD_W-1:0]     cmd;
    logic [HIT_W-1:0]     hits;
  } lpm_entry_t;

  // Mask with the top len bits set; len is at most ADDR_BITS.
  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_BITS{1'b1}} >> len);
  endfunction

  // Saturating increment of a hit counter.
  function automatic logic [HIT_W-1:0] hit_bump(input logic [HIT_W-1:0] cnt);
    return (cnt == {HIT_W{1'b1}}) ? cnt : cnt + HIT_W'(1);
  endfunction

endpackage

// File: src/lpm_front.sv
// ---------------------------------------------------------------------------
// IPv4 longest-prefix match: front end
// Accepts input items, classifies them and holds the work item for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpm_pkg::lpm_in_t    in_data_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lpm_pkg::lpm_work_t  push_data_o
);

  logic               hold_valid_q;
  lpm_pkg::lpm_work_t hold_q;
  lpm_pkg::lpm_work_t work_c;
  logic [lpm_pkg::LEN_W-1:0] len_c;

  // The holding register stalls the port only while the queue refuses it.
  assign in_stall_o   = hold_valid_q && !push_ready_i;
  assign push_valid_o = hold_valid_q;
  assign push_data_o  = hold_q;

  // Clamp the prefix length to the address width.
  assign len_c = (in_data_i.prefix_len > lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS)) ?
                 lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS) : in_data_i.prefix_len;

  // Classify the item and mask an add prefix down to its length.
  always_comb begin
    work_c.op  = lpm_pkg::OP_LOOKUP;
    work_c.key = in_data_i.addr;
    work_c.len = len_c;
    work_c.cmd = in_data_i.rule_cmd;
    if (in_data_i.mode == lpm_pkg::MODE_ADD) begin
      if (in_data_i.rule_cmd == '0) begin
        work_c.op = lpm_pkg::OP_NOP;
      end else if (len_c == '0) begin
        work_c.op = lpm_pkg::OP_ROOT;
      end else begin
        work_c.op  = lpm_pkg::OP_ADD;
        work_c.key = in_data_i.addr & lpm_pkg::prefix_mask(len_c);
      end
    end
  end

  // Holding register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  // Holding register payload.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      hold_q <= work_c;
    end
  end

endmodule

// File: src/lpm_fifo.sv
// ---------------------------------------------------------------------------
// IPv4 longest-prefix match: work queue
// Short first-in first-out queue that decouples the front from the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  lpm_pkg::lpm_work_t  push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output lpm_pkg::lpm_work_t  pop_data_o
);

  localparam int unsigned DEPTH = lpm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpm_pkg::lpm_work_t slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/lpm_back.sv
// ---------------------------------------------------------------------------
// IPv4 longest-prefix match: back end
// Scans the rule memory one entry per cycle, updates it and drives results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_back #(
  parameter int unsigned RULE_ENTRIES = lpm_pkg::RULE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  lpm_pkg::lpm_work_t             pop_data_i,
  input  logic                           cfg_valid_i,
  input  logic [lpm_pkg::CMD_W-1:0]      cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lpm_pkg::lpm_out_t              out_data_o
);

  localparam int unsigned IDX_W = $clog2(RULE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(RULE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Rule memory and per-entry valid bits.
  lpm_pkg::lpm_entry_t mem [RULE_ENTRIES];
  logic [RULE_ENTRIES-1:0] valid_q;

  logic [1:0]                 state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       eval_q;
  logic [IDX_W-1:0]           eval_idx_q;
  lpm_pkg::lpm_entry_t        rd_data_q;
  lpm_pkg::lpm_work_t         cur_q;
  logic                       best_found_q;
  logic [IDX_W-1:0]           best_idx_q;
  lpm_pkg::lpm_entry_t        best_entry_q;
  logic                       free_found_q;
  logic [IDX_W-1:0]           free_idx_q;
  logic [lpm_pkg::CMD_W-1:0]  root_cmd_q;
  logic [lpm_pkg::HIT_W-1:0]  root_hits_q;
  logic [lpm_pkg::CMD_W-1:0]  fallback_q;
  logic                       out_valid_q;
  lpm_pkg::lpm_out_t          out_q;

  logic                       pop;
  logic                       rd_en;
  logic                       ev_valid;
  logic                       lookup_hit;
  logic                       add_hit;
  logic                       take_best;
  logic                       take_free;
  logic                       out_free;
  logic                       fire;
  logic [lpm_pkg::HIT_W-1:0]  best_bump;
  logic [lpm_pkg::HIT_W-1:0]  root_bump;
  logic                       fin_we;
  logic [IDX_W-1:0]           fin_addr;
  lpm_pkg::lpm_entry_t        fin_wdata;
  logic                       fin_set_valid;
  logic                       fin_root_cmd;
  logic                       fin_root_bump;
  lpm_pkg::lpm_out_t          fin_out;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign rd_en       = (state_q == ST_SCAN) && (cnt_q < CNT_W'(RULE_ENTRIES));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = (state_q == ST_FINISH) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Compare the entry read last cycle against the current item.
  assign ev_valid   = eval_q && valid_q[eval_idx_q];
  assign lookup_hit = ev_valid &&
                      ((cur_q.key & lpm_pkg::prefix_mask(rd_data_q.len)) == rd_data_q.prefix) &&
                      (!best_found_q || (rd_data_q.len > best_entry_q.len));
  assign add_hit    = ev_valid && !best_found_q &&
                      (rd_data_q.len == cur_q.len) && (rd_data_q.prefix == cur_q.key);
  assign take_best  = (cur_q.op == lpm_pkg::OP_LOOKUP) ? lookup_hit : add_hit;
  assign take_free  = eval_q && !valid_q[eval_idx_q] && !free_found_q;

  assign best_bump  = lpm_pkg::hit_bump(best_entry_q.hits);
  assign root_bump  = lpm_pkg::hit_bump(root_hits_q);

  // Result and table update at the end of an item.
  always_comb begin
    fin_we        = 1'b0;
    fin_addr      = best_idx_q;
    fin_wdata     = best_entry_q;
    fin_set_valid = 1'b0;
    fin_root_cmd  = 1'b0;
    fin_root_bump = 1'b0;
    fin_out       = '0;
    case (cur_q.op)
      lpm_pkg::OP_LOOKUP: begin
        if (best_found_q) begin
          fin_we             = 1'b1;
          fin_wdata.hits     = best_bump;
          fin_out.result_cmd = best_entry_q.cmd;
          fin_out.matched    = 1'b1;
          fin_out.hit_count  = best_bump;
        end else if (root_cmd_q != '0) begin
          fin_root_bump      = 1'b1;
          fin_out.result_cmd = root_cmd_q;
          fin_out.matched    = 1'b1;
          fin_out.hit_count  = root_bump;
        end else begin
          fin_out.result_cmd = fallback_q;
        end
      end
      lpm_pkg::OP_ADD: begin
        if (best_found_q) begin
          fin_we        = 1'b1;
          fin_wdata.cmd = cur_q.cmd;
        end else if (free_found_q) begin
          fin_we           = 1'b1;
          fin_addr         = free_idx_q;
          fin_wdata.prefix = cur_q.key;
          fin_wdata.len    = cur_q.len;
          fin_wdata.cmd    = cur_q.cmd;
          fin_wdata.hits   = '0;
          fin_set_valid    = 1'b1;
        end else begin
          fin_out.status = 1'b1;
        end
      end
      lpm_pkg::OP_ROOT: begin
        fin_root_cmd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state, valid bits, root rule and fallback register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      eval_q       <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      root_cmd_q   <= '0;
      root_hits_q  <= '0;
      fallback_q   <= lpm_pkg::FALLBACK_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        fallback_q <= cfg_data_i;
      end
      eval_q <= rd_en;
      if (take_best) begin
        best_found_q <= 1'b1;
      end
      if (take_free) begin
        free_found_q <= 1'b1;
      end
      if (out_valid_q && !out_stall_i && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            cnt_q        <= '0;
            best_found_q <= 1'b0;
            free_found_q <= 1'b0;
            if (pop_data_i.op == lpm_pkg::OP_LOOKUP || pop_data_i.op == lpm_pkg::OP_ADD) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            if (fin_set_valid) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            if (fin_root_cmd) begin
              root_cmd_q <= cur_q.cmd;
            end
            if (fin_root_bump) begin
              root_hits_q <= root_bump;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the scan and the result.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_data_i;
    end
    if (rd_en) begin
      eval_idx_q <= cnt_q[IDX_W-1:0];
    end
    if (take_best) begin
      best_idx_q   <= eval_idx_q;
      best_entry_q <= rd_data_q;
    end
    if (take_free) begin
      free_idx_q <= eval_idx_q;
    end
    if (fire) begin
      out_q <= fin_out;
    end
  end

  // Rule memory: one read port for the scan, one write port at the end.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[cnt_q[IDX_W-1:0]];
    end
    if (fire && fin_we) begin
      mem[fin_addr] <= fin_wdata;
    end
  end

  // The scan counter never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(RULE_ENTRIES)))
    else $error("scan counter past table depth");

  // A new result only ever comes from the finishing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside finishing step");

  // A matched result always carries a nonzero command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.matched || (out_q.result_cmd != '0)))
    else $error("matched result with zero command");

  // An unmatched result reports no hits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.matched) |-> (out_q.hit_count == '0))
    else $error("hit count on unmatched result");

  // The queue is popped only while no item is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q != ST_IDLE))
    else $error("popped item not started");

endmodule

// File: src/ipv4_longest_prefix_match_core.sv
// Lookup and add items pass through the back end in steps: a queue pop, a scan
// of one rule memory read per entry plus a compare of the last entry read, and a
// finishing step that waits while the output stalls; root and ignored adds skip
// the scan. Before the back end, items pass the front register and the queue.
// Reset clears all control state, rule valid bits and the root rule at once.
// ---------------------------------------------------------------------------
// IPv4 longest-prefix match core
// Prefix table with per-rule saturating hit counters and a fallback command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_longest_prefix_match_core #(
  parameter int unsigned RULE_ENTRIES = lpm_pkg::RULE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lpm_pkg::lpm_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lpm_pkg::lpm_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lpm_pkg::CMD_W-1:0]  cfg_data_i
);

  logic               push_valid;
  logic               push_ready;
  lpm_pkg::lpm_work_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  lpm_pkg::lpm_work_t pop_data;

  // The fallback register takes every transfer.
  assign cfg_ready_o = 1'b1;

  // Front end: accept and classify.
  lpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Work queue between front and back.
  lpm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: table scan, update and result.
  lpm_back #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
